/* hw/rtl/chs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types, fixed-point constants and the CORDIC angle table for the
// compass heading smoother.
// ----------------------------------------------------------------------------
package chs_pkg;

   // Payload widths
   localparam int AXIS_W    = 16;             // signed axis reading
   localparam int MAG_W     = AXIS_W + 1;     // magnitude, holds 32768
   localparam int HDG_W     = 17;             // heading, Q9.8 degrees
   localparam int DEG_W     = 9;              // whole degrees

   // Angles in Q9.8 degrees
   localparam logic [HDG_W-1:0] DEG90_Q8  = HDG_W'(90 * 256);
   localparam logic [HDG_W-1:0] DEG180_Q8 = HDG_W'(180 * 256);
   localparam logic [HDG_W-1:0] DEG270_Q8 = HDG_W'(270 * 256);
   localparam logic [HDG_W-1:0] DEG360_Q8 = HDG_W'(360 * 256);
   localparam int               DEG360_INT = 360 * 256;

   // CORDIC arctangent
   localparam int CORDIC_STEPS    = 16;
   localparam int CORDIC_PRESHIFT = 14;
   localparam int ITER_W          = $clog2(CORDIC_STEPS);
   localparam int VEC_W           = 33;       // rotating x/y, signed
   localparam int Z_W             = 26;       // angle, Q16 degrees, signed
   localparam int ATAN_W          = 22;
   localparam int ZCLAMP_W        = 23;
   localparam logic [ZCLAMP_W-1:0] DEG90_Q16 = ZCLAMP_W'(90 * 65536);

   // Default ring depth and queue depth
   localparam int CHS_RING_DEPTH  = 8;
   localparam int CHS_QUEUE_DEPTH = 2;

   // How the heading is formed from the first-quadrant angle
   typedef enum logic [2:0] {
      OP_FIXED_0   = 3'd0,
      OP_FIXED_180 = 3'd1,
      OP_90_MINUS  = 3'd2,
      OP_90_PLUS   = 3'd3,
      OP_270_MINUS = 3'd4,
      OP_270_PLUS  = 3'd5
   } op_type;

   // One classified sample on its way to the back end
   typedef struct packed {
      op_type             op;
      logic [MAG_W-1:0]   num;   // |x|
      logic [MAG_W-1:0]   den;   // |y|
   } item_type;

   // atan(2^-i) in degrees with 16 fractional bits
   function automatic logic [ATAN_W-1:0] atan_lut(input logic [ITER_W-1:0] idx);
      logic [ATAN_W-1:0] val;
      begin
         case (idx)
            4'd0:    val = ATAN_W'(2949120);
            4'd1:    val = ATAN_W'(1740967);
            4'd2:    val = ATAN_W'(919879);
            4'd3:    val = ATAN_W'(466945);
            4'd4:    val = ATAN_W'(234379);
            4'd5:    val = ATAN_W'(117304);
            4'd6:    val = ATAN_W'(58666);
            4'd7:    val = ATAN_W'(29335);
            4'd8:    val = ATAN_W'(14668);
            4'd9:    val = ATAN_W'(7334);
            4'd10:   val = ATAN_W'(3667);
            4'd11:   val = ATAN_W'(1833);
            4'd12:   val = ATAN_W'(917);
            4'd13:   val = ATAN_W'(458);
            4'd14:   val = ATAN_W'(229);
            4'd15:   val = ATAN_W'(115);
            default: val = '0;
         endcase
         return val;
      end
   endfunction

endpackage

/* hw/rtl/chs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_front
// Accepts a sample transaction, sorts it into a heading case and splits it
// into axis magnitudes; holds it in a register until the queue takes it.
// ----------------------------------------------------------------------------
module chs_front
   import chs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [AXIS_W-1:0] req_x_value,
   input  logic signed [AXIS_W-1:0] req_y_value,
   output logic                     push_valid,
   input  logic                     push_ready,
   output item_type                 push_item
);

   logic      hold_valid_ff, hold_valid_in;
   item_type  item_ff, item_in;
   logic      accept;
   logic signed [MAG_W-1:0] x_ext, y_ext;
   logic      x_neg, y_neg, y_zero, same_sign;

   assign req_ready  = !hold_valid_ff || push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = hold_valid_ff;
   assign push_item  = item_ff;

   // Classify the sample
   always_comb begin
      x_ext     = {req_x_value[AXIS_W-1], req_x_value};
      y_ext     = {req_y_value[AXIS_W-1], req_y_value};
      x_neg     = req_x_value[AXIS_W-1];
      y_neg     = req_y_value[AXIS_W-1];
      y_zero    = (req_y_value == '0);
      same_sign = (!x_neg) == (!y_neg && !y_zero);

      item_in.num = x_neg ? MAG_W'(-x_ext) : MAG_W'(x_ext);
      item_in.den = y_neg ? MAG_W'(-y_ext) : MAG_W'(y_ext);
      if (y_zero) begin
         item_in.op = x_neg ? OP_FIXED_180 : OP_FIXED_0;
      end else if (!y_neg) begin
         item_in.op = same_sign ? OP_90_MINUS : OP_90_PLUS;
      end else begin
         item_in.op = same_sign ? OP_270_MINUS : OP_270_PLUS;
      end
   end

   // Hold the classified item until the queue takes it
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

/* hw/rtl/chs_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_queue
// Short first-in first-out queue of classified items between the front end
// and the back end.
// ----------------------------------------------------------------------------
module chs_queue
   import chs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = (CHS_QUEUE_DEPTH > 1) ? $clog2(CHS_QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(CHS_QUEUE_DEPTH + 1);

   item_type           slot_ff [CHS_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff,  count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(CHS_QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(CHS_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(CHS_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/chs_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_cordic
// Iterative vectoring CORDIC: one micro-rotation per cycle, sixteen in all,
// giving atan(num/den) in Q9.8 degrees, clamped to 0..90.
// ----------------------------------------------------------------------------
module chs_cordic
   import chs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [MAG_W-1:0]   num,
   input  logic [MAG_W-1:0]   den,
   output logic               done,
   output logic [HDG_W-1:0]   angle
);

   logic                     busy_ff, busy_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic signed [VEC_W-1:0]  cx_ff, cx_in;
   logic signed [VEC_W-1:0]  cy_ff, cy_in;
   logic signed [Z_W-1:0]    z_ff,  z_in;
   logic signed [VEC_W-1:0]  dx, dy;
   logic signed [Z_W-1:0]    step_angle;
   logic [ZCLAMP_W-1:0]      z_clamped;
   logic [ZCLAMP_W:0]        z_rounded;
   logic [HDG_W-1:0]         angle_raw;

   assign done = busy_ff && (iter_ff == ITER_W'(CORDIC_STEPS - 1));

   // One micro-rotation per cycle
   always_comb begin
      dx         = cy_ff >>> iter_ff;
      dy         = cx_ff >>> iter_ff;
      step_angle = $signed({{(Z_W - ATAN_W){1'b0}}, atan_lut(iter_ff)});
      busy_in    = busy_ff;
      iter_in    = iter_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      z_in       = z_ff;
      if (start) begin
         busy_in = 1'b1;
         iter_in = '0;
         cx_in   = $signed(VEC_W'({den, {CORDIC_PRESHIFT{1'b0}}}));
         cy_in   = $signed(VEC_W'({num, {CORDIC_PRESHIFT{1'b0}}}));
         z_in    = '0;
      end else if (busy_ff) begin
         if (!cy_ff[VEC_W-1]) begin
            cx_in = cx_ff + dx;
            cy_in = cy_ff - dy;
            z_in  = z_ff + step_angle;
         end else begin
            cx_in = cx_ff - dx;
            cy_in = cy_ff + dy;
            z_in  = z_ff - step_angle;
         end
         iter_in = iter_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      z_ff  <= z_in;
   end

   // Clamp to 0..90 degrees and round to 8 fractional bits
   always_comb begin
      if (z_ff[Z_W-1]) begin
         z_clamped = '0;
      end else if (z_ff > $signed({{(Z_W - ZCLAMP_W){1'b0}}, DEG90_Q16})) begin
         z_clamped = DEG90_Q16;
      end else begin
         z_clamped = z_ff[ZCLAMP_W-1:0];
      end
      z_rounded = {1'b0, z_clamped} + (ZCLAMP_W + 1)'(128);
      angle_raw = HDG_W'(z_rounded[ZCLAMP_W:8]);
      angle     = (angle_raw > DEG90_Q8) ? DEG90_Q8 : angle_raw;
   end

endmodule

/* hw/rtl/chs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chs_back
// Runs one item at a time: arctangent, heading, ring and running sum update,
// average by reciprocal multiply, and the result output register.
// ----------------------------------------------------------------------------
module chs_back
   import chs_pkg::*;
#(
   parameter int RING_DEPTH = CHS_RING_DEPTH
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  item_type           pop_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [DEG_W-1:0]   rsp_raw_heading,
   output logic [DEG_W-1:0]   rsp_smoothed_heading
);

   localparam int SLOT_W   = $clog2(RING_DEPTH);
   localparam int SUM_W    = $clog2(RING_DEPTH * DEG360_INT);
   localparam int RECIP_SH = SUM_W + $clog2(RING_DEPTH);
   localparam int RECIP_W  = SUM_W + 2;
   localparam longint RECIP_VAL = ((64'sd1 <<< RECIP_SH) + RING_DEPTH - 1) / RING_DEPTH;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
   localparam int PROD_W   = SUM_W + RECIP_W;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_ROTATE  = 6'b000010,
      ST_HEADING = 6'b000100,
      ST_UPDATE  = 6'b001000,
      ST_SCALE   = 6'b010000,
      ST_SEND    = 6'b100000
   } state_type;

   state_type              state_ff, state_in;
   op_type                 op_ff;
   logic [HDG_W-1:0]       heading_ff, heading_in;
   logic [HDG_W-1:0]       last_ff;
   logic [HDG_W-1:0]       ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]      slot_ff;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [PROD_W-1:0]      prod_ff;
   logic                   rsp_valid_ff;
   logic [DEG_W-1:0]       raw_ff, smooth_ff;
   logic                   cordic_start, cordic_done;
   logic [HDG_W-1:0]       angle;
   logic [HDG_W-1:0]       heading_sum;
   logic [HDG_W-1:0]       old_entry, diff;
   logic                   jump;
   logic                   send_load;

   assign pop_ready    = (state_ff == ST_IDLE);
   assign cordic_start = pop_valid && (state_ff == ST_IDLE);
   assign send_load    = (state_ff == ST_SEND) && (!rsp_valid_ff || rsp_ready);

   chs_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .num   (pop_item.num),
      .den   (pop_item.den),
      .done  (cordic_done),
      .angle (angle)
   );

   // Sequence one item through the back end
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:    if (pop_valid)   state_in = ST_ROTATE;
         ST_ROTATE:  if (cordic_done) state_in = ST_HEADING;
         ST_HEADING: state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_SCALE;
         ST_SCALE:   state_in = ST_SEND;
         ST_SEND:    if (send_load)   state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Form the heading from the quadrant case and the angle
   always_comb begin
      case (op_ff)
         OP_FIXED_0:   heading_sum = '0;
         OP_FIXED_180: heading_sum = DEG180_Q8;
         OP_90_MINUS:  heading_sum = DEG90_Q8 - angle;
         OP_90_PLUS:   heading_sum = DEG90_Q8 + angle;
         OP_270_MINUS: heading_sum = DEG270_Q8 - angle;
         OP_270_PLUS:  heading_sum = DEG270_Q8 + angle;
         default:      heading_sum = '0;
      endcase
      heading_in = (heading_sum >= DEG360_Q8) ? heading_sum - DEG360_Q8 : heading_sum;
   end

   // Jump test against the previous entry and running sum update
   always_comb begin
      old_entry = ring_ff[slot_ff];
      diff      = (heading_ff > last_ff) ? heading_ff - last_ff : last_ff - heading_ff;
      jump      = (diff > DEG180_Q8);
      if (jump) begin
         sum_in = SUM_W'(heading_ff) * SUM_W'(RING_DEPTH);
      end else begin
         sum_in = sum_ff - SUM_W'(old_entry) + SUM_W'(heading_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= '0;
         slot_ff      <= '0;
         sum_ff       <= '0;
         for (int i = 0; i < RING_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (send_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_UPDATE) begin
            last_ff <= heading_ff;
            sum_ff  <= sum_in;
            slot_ff <= (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
            for (int i = 0; i < RING_DEPTH; i++) begin
               if (jump || (slot_ff == SLOT_W'(i))) begin
                  ring_ff[i] <= heading_ff;
               end
            end
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cordic_start) begin
         op_ff <= pop_item.op;
      end
      if (state_ff == ST_HEADING) begin
         heading_ff <= heading_in;
      end
      if (state_ff == ST_SCALE) begin
         prod_ff <= PROD_W'(sum_ff) * PROD_W'(RECIP);
      end
      if (send_load) begin
         raw_ff    <= heading_ff[HDG_W-1:8];
         smooth_ff <= prod_ff[RECIP_SH + 16 : RECIP_SH + 8];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_heading      = raw_ff;
   assign rsp_smoothed_heading = smooth_ff;

endmodule

/* hw/rtl/compass_heading_smoother.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_smoother
// Compass heading from a signed X/Y magnetometer sample, with a ring-average
// smoothed heading.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one X/Y sample per transaction (valid/ready).
//   rsp_ channel: one result per sample, raw heading and ring average in
//   whole degrees (valid/ready), in sample order.
//   The back end takes one sample at a time: it takes the item, runs 16 CORDIC
//   micro-rotations on a single shared stage, then does the heading, ring update,
//   reciprocal multiply and output load, and only then takes the next sample.
//   A front register and a two-entry queue keep taking samples while the
//   back end works; when they are full, req_ready drops.
//   If the receiver stalls, the result waits in the output register and the
//   back end finishes the next sample up to the output load, then waits.
//   Reset (synchronous, active high) clears the heading ring, the running
//   sum, the write slot and all handshake state.
// ----------------------------------------------------------------------------
module compass_heading_smoother
   import chs_pkg::*;
#(
   parameter int RING_DEPTH = CHS_RING_DEPTH
)(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [AXIS_W-1:0] req_x_value,
   input  logic signed [AXIS_W-1:0] req_y_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [DEG_W-1:0]         rsp_raw_heading,
   output logic [DEG_W-1:0]         rsp_smoothed_heading
);

   logic     push_valid, push_ready;
   item_type push_item;
   logic     pop_valid, pop_ready;
   item_type pop_item;

   // Accept and classify
   chs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_x_value (req_x_value),
      .req_y_value (req_y_value),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_item   (push_item)
   );

   // Decouple front and back
   chs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Compute heading, smooth and respond
   chs_back #(
      .RING_DEPTH (RING_DEPTH)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_item             (pop_item),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_raw_heading      (rsp_raw_heading),
      .rsp_smoothed_heading (rsp_smoothed_heading)
   );

endmodule
